// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/msld_pkg.sv =====
// ----------------------------------------------------------------------------
// msld_pkg
// Shared widths, types, register codes and line kernels of the line detector
// ----------------------------------------------------------------------------
package msld_pkg;

  localparam int PIX_W       = 8;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_DIM     = 5;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  localparam int THR_W       = 12;
  localparam int WCFG_W      = 9;
  localparam int HCFG_W      = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // nine pixels summed
  localparam int SUM_W       = PIX_W + 4;
  // floor(x / 9) == (x * 7282) >> 16 for every x below 2^13
  localparam int RECIP_W     = 13;
  localparam int RECIP9      = 7282;
  localparam int RECIP_SHIFT = 16;

  // kernel response spans +-6 * max pixel
  localparam int RESP_W      = PIX_W + 4;
  localparam int NUM_KERNELS = 4;
  localparam int KSEL_W      = 2;
  localparam int WIN_SIZE    = 9;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic signed [RESP_W-1:0] resp_t;
  typedef logic signed [2:0] coef_t;
  typedef pix_t win_t [WIN_SIZE];

  localparam pix_t LINE_ON  = '1;
  localparam pix_t LINE_OFF = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_THRESHOLD = 2'd0,
    REG_WIDTH_IN_USE   = 2'd1,
    REG_HEIGHT_IN_USE  = 2'd2
  } cfg_reg_t;

  // per-pixel control carried down the pipeline
  typedef struct packed {
    col_t col;
    logic smooth_ok;
    logic out_ok;
    logic last;
  } pix_ctl_t;

  // horizontal, vertical, rising diagonal, falling diagonal; row 0 on top
  localparam coef_t KERNEL [NUM_KERNELS][WIN_SIZE] = '{
    '{-3'sd1, -3'sd1, -3'sd1,  3'sd2,  3'sd2,  3'sd2, -3'sd1, -3'sd1, -3'sd1},
    '{-3'sd1,  3'sd2, -3'sd1, -3'sd1,  3'sd2, -3'sd1, -3'sd1,  3'sd2, -3'sd1},
    '{-3'sd1, -3'sd1,  3'sd2, -3'sd1,  3'sd2, -3'sd1,  3'sd2, -3'sd1, -3'sd1},
    '{ 3'sd2, -3'sd1, -3'sd1, -3'sd1,  3'sd2, -3'sd1, -3'sd1, -3'sd1,  3'sd2}
  };

  function automatic resp_t kernel_response(input logic [KSEL_W-1:0] k, input win_t w);
    resp_t acc;
    acc = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      acc = acc + resp_t'(KERNEL[k][i]) * $signed({{(RESP_W-PIX_W){1'b0}}, w[i]});
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/msld_mean_stage.sv =====
// ----------------------------------------------------------------------------
// msld_mean_stage
// Raw line store, raw 3x3 window and the 3x3 mean (sum, then divide by 9)
// ----------------------------------------------------------------------------
module msld_mean_stage import msld_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     clr,
  input  col_t     clr_addr,
  input  logic     in_valid,
  input  pix_ctl_t in_ctl,
  input  pix_t     in_pix,
  output logic     out_valid,
  output pix_ctl_t out_ctl,
  output pix_t     out_smooth
);

  // each entry holds {row r-2, row r-1} of one column
  logic [2*PIX_W-1:0] raw_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] raw_rd;

  logic     s1_valid;
  pix_ctl_t s1_ctl;
  pix_t     s1_pix;

  // two older columns of the window; the newest column comes from the store and the incoming pixel
  pix_t raw_win [3][2];
  pix_t new_col [3];

  logic [SUM_W-1:0]         win_sum;
  logic [SUM_W-1:0]         s2_sum;
  logic [SUM_W+RECIP_W-1:0] quot_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_rd  <= raw_mem[in_ctl.col];
      s1_ctl  <= in_ctl;
      s1_pix  <= in_pix;
      out_ctl <= s1_ctl;
      s2_sum  <= win_sum;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          raw_win[r][0] <= raw_win[r][1];
          raw_win[r][1] <= new_col[r];
        end
      end
    end
    if (clr) begin
      raw_mem[clr_addr] <= '0;
    end else if (adv && s1_valid) begin
      raw_mem[s1_ctl.col] <= {raw_rd[PIX_W-1:0], s1_pix};
    end
  end

  assign new_col[0] = raw_rd[2*PIX_W-1:PIX_W];
  assign new_col[1] = raw_rd[PIX_W-1:0];
  assign new_col[2] = s1_pix;

  always_comb begin
    win_sum = '0;
    for (int r = 0; r < 3; r++) begin
      win_sum = win_sum + SUM_W'(raw_win[r][0]) + SUM_W'(raw_win[r][1])
              + SUM_W'(new_col[r]);
    end
  end

  // divide by 9 through the reciprocal
  assign quot_prod  = (SUM_W+RECIP_W)'(s2_sum) * (SUM_W+RECIP_W)'(RECIP9);
  assign out_smooth = quot_prod[RECIP_SHIFT +: PIX_W];

endmodule

// ===== hw/rtl/msld_line_stage.sv =====
// ----------------------------------------------------------------------------
// msld_line_stage
// Smoothed line store, smoothed 3x3 window and the four line kernels
// ----------------------------------------------------------------------------
module msld_line_stage import msld_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    clr,
  input  col_t                    clr_addr,
  input  logic                    in_valid,
  input  pix_ctl_t                in_ctl,
  input  pix_t                    in_smooth,
  input  logic signed [THR_W-1:0] thr,
  output logic                    res_valid,
  output pix_t                    res_line,
  output logic                    res_last
);

  logic [2*PIX_W-1:0] sm_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] sm_rd;

  logic     s3_valid;
  pix_ctl_t s3_ctl;
  pix_t     s3_smooth;
  col_t     rd_addr;
  col_t     s3_addr;

  pix_t sm_win [3][2];
  pix_t new_col [3];
  win_t win;
  logic hit;

  // smoothed column lags the raw column by two
  assign rd_addr = in_ctl.col - col_t'(2);
  assign s3_addr = s3_ctl.col - col_t'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_rd     <= sm_mem[rd_addr];
      s3_ctl    <= in_ctl;
      s3_smooth <= in_smooth;
      if (s3_valid && s3_ctl.smooth_ok) begin
        for (int r = 0; r < 3; r++) begin
          sm_win[r][0] <= sm_win[r][1];
          sm_win[r][1] <= new_col[r];
        end
      end
    end
    if (clr) begin
      sm_mem[clr_addr] <= '0;
    end else if (adv && s3_valid && s3_ctl.smooth_ok) begin
      sm_mem[s3_addr] <= {sm_rd[PIX_W-1:0], s3_smooth};
    end
  end

  assign new_col[0] = sm_rd[2*PIX_W-1:PIX_W];
  assign new_col[1] = sm_rd[PIX_W-1:0];
  assign new_col[2] = s3_smooth;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = sm_win[r][0];
      win[r*3 + 1] = sm_win[r][1];
      win[r*3 + 2] = new_col[r];
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_KERNELS; k++) begin
      hit = hit | (kernel_response(KSEL_W'(k), win) > thr);
    end
  end

  assign res_valid = s3_valid && s3_ctl.out_ok;
  assign res_line  = hit ? LINE_ON : LINE_OFF;
  assign res_last  = s3_ctl.last;

endmodule

// ===== hw/rtl/mean_smooth_line_detect_unit.sv =====
// ----------------------------------------------------------------------------
// mean_smooth_line_detect_unit
// 3x3 mean smoothing followed by four 3x3 line kernels on a pixel stream
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and keeps taking one per clock
// while the output side is free; a result appears on out_valid once the pixel
// that completes its window has passed the store read, window sum, smoothed
// store read and kernels, each one register deep. A two-entry output
// (register plus skid) lets the pipeline run one more result while the
// result on the port waits; in_stall rises when both are full. Only
// fully valid windows give results, so a frame of W x H pixels yields
// (W-4) x (H-4) results, the last one with frame_end set. After reset both
// line stores are zeroed one column per cycle, and in_stall stays high until
// the last column is cleared.
`include "assert_macros.svh"

module mean_smooth_line_detect_unit import msld_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_t                  pixel_in,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_t                  line_pixel,
  output logic                  frame_end,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [THR_W-1:0] edge_threshold;
  logic [WCFG_W-1:0]       width_in_use;
  logic [HCFG_W-1:0]       height_in_use;
  logic [WCFG_W-1:0]       eff_width;
  logic [HCFG_W-1:0]       eff_height;

  col_t col, col_next, cur_col;
  row_t row, row_next, cur_row;
  logic last_col, last_row;
  logic in_accept;
  logic adv;

  logic clearing;
  col_t clr_addr;

  pix_ctl_t s0_ctl;
  logic     mean_valid;
  pix_ctl_t mean_ctl;
  pix_t     mean_smooth;

  logic res_valid;
  pix_t res_line;
  logic res_last;
  logic res_push;

  logic skid_valid;
  pix_t skid_line;
  logic skid_last;
  logic out_take;
  logic out_valid_next;
  logic skid_valid_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= '0;
      width_in_use   <= WCFG_W'(200);
      height_in_use  <= HCFG_W'(200);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
        REG_WIDTH_IN_USE:   width_in_use   <= cfg_data[WCFG_W-1:0];
        REG_HEIGHT_IN_USE:  height_in_use  <= cfg_data[HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_width = width_in_use;
    if (width_in_use < WCFG_W'(MIN_DIM)) begin
      eff_width = WCFG_W'(MIN_DIM);
    end else if (width_in_use > WCFG_W'(MAX_WIDTH)) begin
      eff_width = WCFG_W'(MAX_WIDTH);
    end
    eff_height = height_in_use;
    if (height_in_use < HCFG_W'(MIN_DIM)) begin
      eff_height = HCFG_W'(MIN_DIM);
    end else if (height_in_use > HCFG_W'(MAX_HEIGHT)) begin
      eff_height = HCFG_W'(MAX_HEIGHT);
    end
  end

  // zero both line stores after reset, one column per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + col_t'(1);
      if (clr_addr == col_t'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // position of the incoming pixel
  assign adv       = !skid_valid;
  assign in_stall  = skid_valid || clearing;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cur_col = frame_start ? '0 : col;
    cur_row = frame_start ? '0 : row;
    // counters may sit outside a new, smaller frame size
    if (WCFG_W'(cur_col) >= eff_width) begin
      cur_col = '0;
    end
    if (HCFG_W'(cur_row) >= eff_height) begin
      cur_row = '0;
    end
    last_col = (WCFG_W'(cur_col) + WCFG_W'(1)) >= eff_width;
    last_row = (HCFG_W'(cur_row) + HCFG_W'(1)) >= eff_height;
    col_next = last_col ? '0 : cur_col + col_t'(1);
    row_next = cur_row;
    if (last_col) begin
      row_next = last_row ? '0 : cur_row + row_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  assign s0_ctl.col       = cur_col;
  assign s0_ctl.smooth_ok = (cur_row >= row_t'(2)) && (cur_col >= col_t'(2));
  assign s0_ctl.out_ok    = (cur_row >= row_t'(4)) && (cur_col >= col_t'(4));
  assign s0_ctl.last      = last_col && last_row;

  msld_mean_stage u_mean (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .clr        (clearing),
    .clr_addr   (clr_addr),
    .in_valid   (in_accept),
    .in_ctl     (s0_ctl),
    .in_pix     (pixel_in),
    .out_valid  (mean_valid),
    .out_ctl    (mean_ctl),
    .out_smooth (mean_smooth)
  );

  msld_line_stage u_line (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .clr       (clearing),
    .clr_addr  (clr_addr),
    .in_valid  (mean_valid),
    .in_ctl    (mean_ctl),
    .in_smooth (mean_smooth),
    .thr       (edge_threshold),
    .res_valid (res_valid),
    .res_line  (res_line),
    .res_last  (res_last)
  );

  // output register with a skid entry behind it
  assign res_push        = res_valid && adv;
  assign out_take        = !out_valid || !out_stall;
  assign out_valid_next  = out_take ? (skid_valid || res_push) : 1'b1;
  assign skid_valid_next = out_take ? 1'b0 : (skid_valid || res_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      line_pixel <= skid_valid ? skid_line : res_line;
      frame_end  <= skid_valid ? skid_last : res_last;
    end else if (res_push) begin
      skid_line <= res_line;
      skid_last <= res_last;
    end
  end

  `ASSERT_NXT(a_skid_drains, clk, rst, !out_valid || !out_stall, !skid_valid)
  `ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMP(a_line_level, clk, rst, out_valid, line_pixel == LINE_ON || line_pixel == LINE_OFF)

endmodule

// ===== bench/mean_smooth_line_detect_unit_tb.sv =====
// ----------------------------------------------------------------------------
// mean_smooth_line_detect_unit_tb
// Self-checking bench for the smoothed line detector
// ----------------------------------------------------------------------------
// A short checkerboard frame comes first, with the one result it gives typed
// in. Random frames follow, built from stripes, diagonals and noise, over
// a range of thresholds and image sizes that includes the extremes and
// out-of-range register values. Frames sometimes overrun without
// frame_start, and frame_start sometimes lands mid-frame. A predictor in
// the bench computes the mark and the frame_end flag expected for every
// accepted pixel, and each result taken from the block is compared with
// the oldest prediction. Both handshakes idle in random bursts. The output
// also holds off for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module mean_smooth_line_detect_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msld_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 80;
  localparam int TAIL_CYCLES   = 20;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int DIRECTED_ROWS = 25;

  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_t;

  typedef struct packed {
    pix_t mark;
    logic last;
  } line_mark_t;

  typedef struct packed {
    pix_t pix;
    logic fs;
    logic typed;
    pix_t mark;
    logic last;
  } directed_row_t;

  typedef enum int {PAT_NOISE, PAT_COLUMNS, PAT_ROWS, PAT_RISING, PAT_FALLING} pattern_t;

  // horizontal, vertical, two diagonals; element 0 is the top left
  localparam int LINE_KERNELS [NUM_KERNELS][WIN_SIZE] = '{
    '{-1, -1, -1,  2,  2,  2, -1, -1, -1},
    '{-1,  2, -1, -1,  2, -1, -1,  2, -1},
    '{-1, -1,  2, -1,  2, -1,  2, -1, -1},
    '{ 2, -1, -1, -1,  2, -1, -1, -1,  2}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  pix_t                  pixel_in;
  logic                  frame_start;
  logic                  out_valid;
  logic                  out_stall;
  pix_t                  line_pixel;
  logic                  frame_end;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mean_smooth_line_detect_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_pixel  (line_pixel),
    .frame_end   (frame_end),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // bench-side image of the block
  pix_t                  raw_rows [2*MAX_WIDTH];
  pix_t                  smooth_rows [2*MAX_WIDTH];
  window_t               raw_win;
  window_t               smooth_win;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [THR_W-1:0]      thr_reg;
  logic [WCFG_W-1:0]     width_reg;
  logic [HCFG_W-1:0]     height_reg;

  line_mark_t            pending_marks [$];
  int                    mismatch_count = 0;
  bit                    in_idle_en = 1'b1;
  bit                    out_idle_en = 1'b1;
  bit                    hold_req = 1'b0;
  int                    hold_left = 0;
  int                    stall_left = 0;

  pattern_t              pat_kind;
  int                    pat_period;
  int                    pat_duty;
  int                    pat_hi;
  int                    pat_lo;
  int                    pat_noise;

  // 5x5 checkerboard; any response beats the lowest threshold
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'd255, 1'b1, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b0, LINE_OFF, 1'b0}, '{8'd0,   1'b0, 1'b0, LINE_OFF, 1'b0},
    '{8'd255, 1'b0, 1'b1, LINE_ON,  1'b1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("mean_smooth_line_detect_unit_tb: FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic reset_predictor();
    for (int i = 0; i < 2*MAX_WIDTH; i++) begin
      raw_rows[i] = '0;
      smooth_rows[i] = '0;
    end
    raw_win = '0;
    smooth_win = '0;
    col_pos = 0;
    row_pos = 0;
    thr_reg = '0;
    width_reg = 9'd200;
    height_reg = 13'd200;
  endtask

  // drop the left column, put the new one on the right
  function automatic window_t shift_column(window_t w, pix_t top, pix_t mid, pix_t bot);
    window_t n;
    n = w;
    for (int rr = 0; rr < 3; rr++) begin
      n[rr*3]   = w[rr*3+1];
      n[rr*3+1] = w[rr*3+2];
    end
    n[2] = top;
    n[5] = mid;
    n[8] = bot;
    return n;
  endfunction

  task automatic predict_line_mark(input pix_t p, input logic fs, output logic produced,
                                   output line_mark_t res);
    int unsigned w, h, c, r, sc, sum;
    int thr, acc;
    logic hit;
    w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < MIN_DIM) ? MIN_DIM : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    produced = 1'b0;
    res = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a size change can leave the position outside the new frame
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;

    raw_win = shift_column(raw_win, raw_rows[MAX_WIDTH + c], raw_rows[c], p);
    raw_rows[MAX_WIDTH + c] = raw_rows[c];
    raw_rows[c] = p;

    if (r >= 2 && c >= 2) begin
      sum = 0;
      for (int i = 0; i < WIN_SIZE; i++) sum += raw_win[i];
      sc = c - 2;
      smooth_win = shift_column(smooth_win, smooth_rows[MAX_WIDTH + sc], smooth_rows[sc],
                                pix_t'(sum / 9));
      smooth_rows[MAX_WIDTH + sc] = smooth_rows[sc];
      smooth_rows[sc] = pix_t'(sum / 9);

      if (r >= 4 && c >= 4) begin
        thr = $signed(thr_reg);
        hit = 1'b0;
        for (int k = 0; k < NUM_KERNELS; k++) begin
          acc = 0;
          for (int i = 0; i < WIN_SIZE; i++) acc += LINE_KERNELS[k][i] * int'(smooth_win[i]);
          if (acc > thr) hit = 1'b1;
        end
        produced = 1'b1;
        res.mark = hit ? LINE_ON : LINE_OFF;
        res.last = (r == h - 1) && (c == w - 1);
      end
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic send_pixel(input pix_t p, input logic fs, output logic produced,
                            output line_mark_t res);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line_mark(p, fs, produced, res);
    if (produced) pending_marks.push_back(res);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_marks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_EDGE_THRESHOLD: thr_reg = data[THR_W-1:0];
      REG_WIDTH_IN_USE:   width_reg = data[WCFG_W-1:0];
      REG_HEIGHT_IN_USE:  height_reg = data[HCFG_W-1:0];
      default: ;
    endcase
  endtask

  // unused high bits of the data word carry noise
  task automatic configure(input int thr, input int wcfg, input int hcfg);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[THR_W-1:0] = THR_W'(thr);
    write_reg(REG_EDGE_THRESHOLD, d);
    d = CFG_DATA_W'($urandom);
    d[WCFG_W-1:0] = WCFG_W'(wcfg);
    write_reg(REG_WIDTH_IN_USE, d);
    d = CFG_DATA_W'(hcfg);
    write_reg(REG_HEIGHT_IN_USE, d);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_threshold();
    return int'($urandom_range(0, 320)) - 80;
  endfunction

  task automatic pick_pattern();
    pat_kind   = pattern_t'($urandom_range(0, 4));
    pat_period = $urandom_range(2, 6);
    pat_duty   = $urandom_range(1, pat_period - 1);
    pat_hi     = $urandom_range(0, 255);
    pat_lo     = $urandom_range(0, 255);
    pat_noise  = $urandom_range(0, 20);
  endtask

  function automatic pix_t pattern_pixel(int c, int r);
    int v;
    case (pat_kind)
      PAT_COLUMNS: v = ((c % pat_period) < pat_duty) ? pat_hi : pat_lo;
      PAT_ROWS:    v = ((r % pat_period) < pat_duty) ? pat_hi : pat_lo;
      PAT_RISING:  v = (((c + r) % pat_period) < pat_duty) ? pat_hi : pat_lo;
      PAT_FALLING: v = (((c + 4096 - r) % pat_period) < pat_duty) ? pat_hi : pat_lo;
      default:     v = $urandom_range(0, 255);
    endcase
    v = v + int'($urandom_range(0, 2 * pat_noise)) - pat_noise;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // mostly whole frames; now and then an overrun or a restart mid-frame
  task automatic run_phase(input int thr, input int wcfg, input int hcfg, input int n_items,
                           input int hold_at, input int drain_at);
    logic fs, produced;
    line_mark_t res;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    configure(thr, wcfg, hcfg);
    pick_pattern();
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == drain_at) wait_for_results();
      if (i == 0) fs = 1'($urandom_range(0, 1));
      else if (col_pos == 0 && row_pos == 0) fs = ($urandom_range(0, 9) != 0);
      else fs = ($urandom_range(0, 59) == 0);
      if (fs || (col_pos == 0 && row_pos == 0)) pick_pattern();
      send_pixel(pattern_pixel(col_pos, row_pos), fs, produced, res);
    end
  endtask

  initial begin : result_side
    line_mark_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_marks.size() == 0) begin
          flag_mismatch($sformatf("unexpected item: line_pixel %0d frame_end %b",
                                  line_pixel, frame_end));
        end else begin
          want = pending_marks.pop_front();
          if (line_pixel !== want.mark)
            flag_mismatch($sformatf("line_pixel %0d, predicted %0d", line_pixel, want.mark));
          if (frame_end !== want.last)
            flag_mismatch($sformatf("frame_end %b, predicted %b", frame_end, want.last));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic produced;
    line_mark_t res;
    rst = 1'b1;
    in_valid = 1'b0;
    pixel_in = '0;
    frame_start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_EDGE_THRESHOLD;
    cfg_data = '0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    configure(-2048, MIN_DIM, MIN_DIM);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_pixel(directed_rows[i].pix, directed_rows[i].fs, produced, res);
      if (directed_rows[i].typed && (!produced || res.mark != directed_rows[i].mark ||
                                     res.last != directed_rows[i].last))
        flag_mismatch($sformatf("directed row %0d: predicted %0d last %b, typed %0d last %b",
                                i, res.mark, res.last, directed_rows[i].mark,
                                directed_rows[i].last));
    end

    run_phase(2047, MIN_DIM, MIN_DIM, 40, -1, -1);
    run_phase(pick_threshold(), 8, 7, 120, 20, 80);
    run_phase(pick_threshold(), $urandom_range(0, 4), $urandom_range(0, 4), 40, -1, -1);
    // full width runs the column count up to its top value and back to zero
    run_phase(pick_threshold(), MAX_WIDTH, MIN_DIM, 260, -1, -1);
    run_phase(pick_threshold(), $urandom_range(257, 511), $urandom_range(5, 8), 30, -1, -1);
    run_phase(pick_threshold(), 6, MAX_HEIGHT, 50, -1, -1);
    run_phase(pick_threshold(), 7, $urandom_range(4097, 8191), 40, -1, -1);
    run_phase(pick_threshold(), $urandom_range(5, 12), $urandom_range(5, 10), 60, -1, 30);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    run_phase(pick_threshold(), $urandom_range(5, 10), $urandom_range(5, 8), 60, -1, -1);

    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_marks.size() != 0; n++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_marks.size() != 0)
      flag_mismatch($sformatf("%0d predicted items never came out", pending_marks.size()));
    if (mismatch_count == 0) begin
      $display("mean_smooth_line_detect_unit_tb: PASS");
    end else begin
      $display("mean_smooth_line_detect_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/msld_pkg.sv
hw/rtl/msld_mean_stage.sv
hw/rtl/msld_line_stage.sv
hw/rtl/mean_smooth_line_detect_unit.sv
bench/mean_smooth_line_detect_unit_tb.sv
